// ----- hw/rtl/chs_pkg.sv -----
// Package for the cosine hemisphere sampler: fixed constants and the CORDIC angle table.
// It has no dependencies. The pipeline stages and the top level use it.
`timescale 1ns / 1ps
package chs_pkg;

  localparam int CordicSteps = 16;
  localparam int RandWidth   = 16;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic [31:0] InvPiQ32 = 32'd1367130551;

  // Arctangent of 2^-i, in units of 2^-32 turn.
  function automatic logic signed [33:0] atan_turn(input int idx);
    logic signed [33:0] v;
    begin
      case (idx)
        0: v = 34'sd536870912;
        1: v = 34'sd316933406;
        2: v = 34'sd167458907;
        3: v = 34'sd85004756;
        4: v = 34'sd42667331;
        5: v = 34'sd21354465;
        6: v = 34'sd10679838;
        7: v = 34'sd5340245;
        8: v = 34'sd2670163;
        9: v = 34'sd1335087;
        10: v = 34'sd667544;
        11: v = 34'sd333772;
        12: v = 34'sd166886;
        13: v = 34'sd83443;
        14: v = 34'sd41722;
        15: v = 34'sd20861;
        default: v = 34'sd0;
      endcase
      return v;
    end
  endfunction

  // Per-stage control word that travels with the data.
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

// ----- hw/rtl/chs_cordic_step.sv -----
// One registered CORDIC rotation step for the azimuth sine and cosine.
// It depends on chs_pkg for the angle table.
`timescale 1ns / 1ps
module chs_cordic_step
  import chs_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [33:0]  x_in,
  input  logic signed [33:0]  y_in,
  input  logic signed [33:0]  z_in,
  output logic signed [33:0]  x_out,
  output logic signed [33:0]  y_out,
  output logic signed [33:0]  z_out
);

  logic signed [33:0] x_nxt, y_nxt, z_nxt;
  logic signed [33:0] x_r, y_r, z_r;

  // Rotate toward zero remaining angle.
  always_comb begin
    if (!z_in[33]) begin
      x_nxt = x_in - (y_in >>> STEP);
      y_nxt = y_in + (x_in >>> STEP);
      z_nxt = z_in - atan_turn(STEP);
    end else begin
      x_nxt = x_in + (y_in >>> STEP);
      y_nxt = y_in - (x_in >>> STEP);
      z_nxt = z_in + atan_turn(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

// ----- hw/rtl/cosine_hemisphere_sampler.sv -----
// Top level of the cosine-weighted hemisphere sampler pipeline.
// It depends on chs_pkg and chs_cordic_step.
// Throughput is one item per cycle while the output is not stalled.
// The pipeline is a seed stage, 16 CORDIC stages with the square roots alongside,
// then quadrant, weight, product, sum and output stages.
// The whole pipeline advances together; a stalled output holds every stage.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps
module cosine_hemisphere_sampler
  import chs_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // axis_x_x, axis_x_y, axis_x_z, axis_y_x..z, axis_z_x..z, rand_azimuth, rand_elevation
  input  logic [((9*DATA_WIDTH+32+7)/8)*8-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // dir_x, dir_y, dir_z, density
  output logic [((3*DATA_WIDTH+16+7)/8)*8-1:0] out_tdata
);

  localparam int W = DATA_WIDTH;
  localparam int Depth = CordicSteps + 6;
  localparam int OutW = ((3*DATA_WIDTH+16+7)/8)*8;

  logic en;
  stage_ctl_t ctl_r [Depth];

  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Depth; i++) ctl_r[i].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0].valid <= in_tvalid;
      for (int i = 1; i < Depth; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end
  assign out_tvalid = ctl_r[Depth-1].valid;

  // Axis data and quadrant delay lines, one tap per stage.
  logic [9*W-1:0] ax_r [Depth-3];
  logic [1:0]     quad_r [CordicSteps+1];
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= in_tdata[9*W-1:0];
      for (int i = 1; i < Depth-3; i++) ax_r[i] <= ax_r[i-1];
      quad_r[0] <= in_tdata[9*W+15 -: 2];
      for (int i = 1; i <= CordicSteps; i++) quad_r[i] <= quad_r[i-1];
    end
  end

  // Stage 0: CORDIC seed.
  logic signed [33:0] cx [CordicSteps+1];
  logic signed [33:0] cy [CordicSteps+1];
  logic signed [33:0] cz [CordicSteps+1];
  logic signed [33:0] x0_r, z0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= CordicGainQ30;
      z0_r <= {4'b0, in_tdata[9*W +: 14], 16'b0};
    end
  end
  assign cx[0] = x0_r;
  assign cy[0] = '0;
  assign cz[0] = z0_r;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    chs_cordic_step #(.STEP(g)) u_step (
      .clk(clk), .en(en),
      .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1])
    );
  end

  // Square roots: 17 result bits, one bit per CORDIC stage alongside, then bit 0 after them.
  logic [33:0] rc_rem_r [CordicSteps+1];
  logic [16:0] rc_root_r [CordicSteps+1];
  logic [33:0] rs_rem_r [CordicSteps+1];
  logic [16:0] rs_root_r [CordicSteps+1];
  always_ff @(posedge clk) begin
    if (en) begin
      rc_rem_r[0] <= {1'b0, 17'd65536 - {1'b0, in_tdata[9*W+16 +: 16]}, 16'b0};
      rc_root_r[0] <= '0;
      rs_rem_r[0] <= {2'b0, in_tdata[9*W+16 +: 16], 16'b0};
      rs_root_r[0] <= '0;
    end
  end
  // Bit-at-a-time restoring square root; root is built from the top bit down.
  for (genvar g = 0; g < CordicSteps; g++) begin : g_sqrt
    localparam int B = 16 - g;
    logic [33:0] tc, ts;
    logic [16:0] nc, ns;
    always_comb begin
      nc = rc_root_r[g] | (17'd1 << B);
      ns = rs_root_r[g] | (17'd1 << B);
      tc = 34'({17'd0, nc} * {17'd0, nc});
      ts = 34'({17'd0, ns} * {17'd0, ns});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rc_rem_r[g+1] <= rc_rem_r[g];
        rs_rem_r[g+1] <= rs_rem_r[g];
        rc_root_r[g+1] <= (tc <= rc_rem_r[g]) ? nc : rc_root_r[g];
        rs_root_r[g+1] <= (ts <= rs_rem_r[g]) ? ns : rs_root_r[g];
      end
    end
  end
  // Final bit 0 of each root.
  logic [16:0] cth_r, sth_r;
  logic [16:0] nc0, ns0;
  logic [33:0] tc0, ts0;
  always_comb begin
    nc0 = rc_root_r[CordicSteps] | 17'd1;
    ns0 = rs_root_r[CordicSteps] | 17'd1;
    tc0 = 34'({17'd0, nc0} * {17'd0, nc0});
    ts0 = 34'({17'd0, ns0} * {17'd0, ns0});
  end

  // Quadrant map and rounding to Q.16.
  logic signed [33:0] c_sel, s_sel;
  logic signed [33:0] cr, sr;
  logic signed [18:0] cphi_r, sphi_r;
  always_comb begin
    case (quad_r[CordicSteps])
      2'd0: begin c_sel = cx[CordicSteps]; s_sel = cy[CordicSteps]; end
      2'd1: begin c_sel = -cy[CordicSteps]; s_sel = cx[CordicSteps]; end
      2'd2: begin c_sel = -cx[CordicSteps]; s_sel = -cy[CordicSteps]; end
      default: begin c_sel = cy[CordicSteps]; s_sel = -cx[CordicSteps]; end
    endcase
    cr = (c_sel + 34'sd8192) >>> 14;
    sr = (s_sel + 34'sd8192) >>> 14;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cphi_r <= cr[18:0];
      sphi_r <= sr[18:0];
      cth_r <= (tc0 <= rc_rem_r[CordicSteps]) ? nc0 : rc_root_r[CordicSteps];
      sth_r <= (ts0 <= rs_rem_r[CordicSteps]) ? ns0 : rs_root_r[CordicSteps];
    end
  end

  // Tangent weights.
  logic signed [37:0] pa, pb;
  logic signed [21:0] a_r, b_r;
  logic [16:0] cth2_r, cth3_r;
  assign pa = $signed({1'b0, sth_r}) * cphi_r + 38'sd32768;
  assign pb = $signed({1'b0, sth_r}) * sphi_r + 38'sd32768;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= 22'(pa >>> 16);
      b_r <= 22'(pb >>> 16);
      cth2_r <= cth_r;
    end
  end

  // Products, one register stage, then sum and round.
  logic [9*W-1:0] axd;
  assign axd = ax_r[Depth-4];
  logic signed [W+22:0] pxa_r [3];
  logic signed [W+22:0] pyb_r [3];
  logic signed [W+22:0] pzc_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pxa_r[k] <= $signed(axd[k*W +: W]) * a_r;
        pyb_r[k] <= $signed(axd[(3+k)*W +: W]) * b_r;
        pzc_r[k] <= $signed(axd[(6+k)*W +: W]) * $signed({5'b0, cth2_r});
      end
      cth3_r <= cth2_r;
    end
  end

  logic signed [W+24:0] sum_r [3];
  logic [48:0] dprod_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        sum_r[k] <= (W+25)'(pxa_r[k]) + (W+25)'(pyb_r[k]) + (W+25)'(pzc_r[k])
                    + (W+25)'(32768);
      dprod_r <= 49'({32'd0, cth3_r} * {17'd0, InvPiQ32}) + 49'h80000000;
    end
  end

  // Saturate and pack.
  logic signed [W+8:0] sh [3];
  logic [W-1:0] sat [3];
  logic [OutW-1:0] out_nxt, out_r;
  always_comb begin
    out_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      sh[k] = (W+9)'(sum_r[k] >>> 16);
      if (sh[k] > $signed((W+9)'((1 << (W-1)) - 1)))
        sat[k] = {1'b0, {(W-1){1'b1}}};
      else if (sh[k] < -$signed((W+9)'(1 << (W-1))))
        sat[k] = {1'b1, {(W-1){1'b0}}};
      else
        sat[k] = sh[k][W-1:0];
      out_nxt[k*W +: W] = sat[k];
    end
    out_nxt[3*W +: 16] = dprod_r[47:32];
  end
  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end
  assign out_tdata = out_r;

  logic unused_ok;
  assign unused_ok = ^{cz[CordicSteps], dprod_r[48], dprod_r[31:0]};

endmodule

// ----- tb/tb_cosine_hemisphere_sampler.sv -----
// Testbench for the cosine hemisphere sampler: random and directed sample requests.
// It depends on chs_pkg and the cosine_hemisphere_sampler top level.
`timescale 1ns / 1ps
module tb_cosine_hemisphere_sampler
  import chs_pkg::*;
;

  localparam int DW = 16;
  localparam int IN_W = ((9*DW+32+7)/8)*8;
  localparam int OUT_W = ((3*DW+16+7)/8)*8;
  localparam int LATENCY = 21;

  typedef struct packed {
    logic [15:0]          density;
    logic signed [DW-1:0] dz;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dx;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [IN_W-1:0] pending_items[$];
  sample_t expected_samples[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;

  always #2 clk = ~clk;

  cosine_hemisphere_sampler #(.DATA_WIDTH(DW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint v);
    longint r;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
    end
    return r;
  endfunction

  // Computes the direction and density for one sample request.
  function automatic sample_t sample_direction(logic [IN_W-1:0] d);
    longint ax[3], ay[3], az[3];
    longint x, y, z, dx, dy, c, s, cth, sth, a, b, sum, lim;
    logic [31:0] phase;
    logic [15:0] u1, u2;
    logic [63:0] dens;
    sample_t r;
    for (int k = 0; k < 3; k++) begin
      ax[k] = $signed(d[k*DW +: DW]);
      ay[k] = $signed(d[(3+k)*DW +: DW]);
      az[k] = $signed(d[(6+k)*DW +: DW]);
    end
    u1 = d[9*DW +: 16];
    u2 = d[9*DW+16 +: 16];
    phase = {u1, 16'h0};
    z = phase[29:0];
    x = CordicGainQ30;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn(i);
      end else begin
        x += dx; y -= dy; z += atan_turn(i);
      end
    end
    // Quadrant fold of the rotated vector.
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = asr(c + 8192, 14);
    s = asr(s + 8192, 14);
    cth = isqrt((65536 - longint'(u2)) << 16);
    sth = isqrt(longint'(u2) << 16);
    a = asr(sth * c + 32768, 16);
    b = asr(sth * s + 32768, 16);
    lim = 64'sd1 <<< (DW - 1);
    for (int k = 0; k < 3; k++) begin
      sum = asr(a * ax[k] + b * ay[k] + cth * az[k] + 32768, 16);
      if (sum > lim - 1) sum = lim - 1;
      if (sum < -lim) sum = -lim;
      if (k == 0) r.dx = sum[DW-1:0];
      else if (k == 1) r.dy = sum[DW-1:0];
      else r.dz = sum[DW-1:0];
    end
    dens = (64'(cth) * InvPiQ32 + 64'h8000_0000) >> 32;
    r.density = dens[15:0];
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return DW'($urandom());
    endcase
  endfunction

  function automatic logic [IN_W-1:0] make_item(int kind);
    logic [IN_W-1:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*DW +: DW] = rand_axis();
    // Kind 0 uses axis values in [-16384, 16384], where the output stays in range.
    if (kind == 0) begin
      for (int k = 0; k < 9; k++)
        d[k*DW +: DW] = DW'($signed($urandom_range(0, 32768)) - 16384);
    end
    d[9*DW +: 16] = 16'($urandom());
    d[9*DW+16 +: 16] = 16'($urandom());
    return d;
  endfunction

  // Driver: presents queued items, idling at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata <= pending_items[0];
          expected_samples.push_back(sample_direction(pending_items[0]));
          void'(pending_items.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    sample_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[3*DW+15:0];
      if (expected_samples.size() == 0) begin
        $error("unexpected result %h", got);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (got.dx !== want.dx) begin
          $error("dir_x expected %0d got %0d", want.dx, got.dx); fail_count++;
        end
        if (got.dy !== want.dy) begin
          $error("dir_y expected %0d got %0d", want.dy, got.dy); fail_count++;
        end
        if (got.dz !== want.dz) begin
          $error("dir_z expected %0d got %0d", want.dz, got.dz); fail_count++;
        end
        if (got.density !== want.density) begin
          $error("density expected %0d got %0d", want.density, got.density); fail_count++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_samples.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] d;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: identity frame over key angles, field extremes and u2 of zero.
    for (int i = 0; i < 20; i++) begin
      d = '0;
      d[0 +: DW] = 16'sd16384;
      d[4*DW +: DW] = 16'sd16384;
      d[8*DW +: DW] = 16'sd16384;
      d[9*DW +: 16] = 16'(i * 16'h2000);
      d[9*DW+16 +: 16] = (i % 4 == 0) ? 16'h0 : (i % 4 == 1) ? 16'hFFFF : 16'(i * 3121);
      if (i >= 16) for (int k = 0; k < 9; k++)
        d[k*DW +: DW] = (i[0]) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      pending_items.push_back(d);
    end
    drain();
    // Random phases with different idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 83 : 27) : 0;
      recv_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 27 : 0;
      for (int i = 0; i < 375; i++) pending_items.push_back(make_item($urandom_range(0, 3)));
      if (ph == 1) begin
        while (pending_items.size() > 200) @(posedge clk);
        // Pause the sender until every outstanding result has come back.
        hold_send = 1'b1;
        while (in_tvalid || expected_samples.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
